/* hw/rtl/ssc_pkg.sv */
// sorted size class stats table: shared types, constants and entry update functions
// used by the table cell, the top level and the testbench; no dependencies
`default_nettype none

package ssc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CFG_W       = 5;
    localparam int IDX_W       = 4;

    localparam logic [CFG_W-1:0] PAGE_LOG2_RESET = 5'd12;
    localparam logic [31:0]      MIN_PAGES       = 32'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } opcode_t;

    // one size class as held in a cell
    typedef struct packed {
        logic [31:0] size_pages;
        logic [31:0] pages_seen;
        logic [31:0] entries;
        logic [31:0] used_min;
        logic [31:0] used_max;
        logic [63:0] used_sum;
        logic [31:0] free_min;
        logic [31:0] free_max;
        logic [63:0] free_sum;
    } entry_t;

    // page values broadcast to every cell
    typedef struct packed {
        logic [31:0] pages;
        logic [31:0] used;
        logic [31:0] spare;
        logic [31:0] ents;
    } page_t;

    // compare flags a cell hands to its right neighbor
    typedef struct packed {
        logic valid;
        logic eq;
        logic gt;
        logic cand;
    } cell_flags_t;

    // per-cell control from the top level
    typedef struct packed {
        logic upd_en;
        logic new_class;
        logic rd_sel;
    } cell_ctl_t;

    // fold one page into a class
    function automatic entry_t fold_page(entry_t e, page_t p);
        entry_t r;
        r = e;
        r.pages_seen = e.pages_seen + 32'd1;
        if (p.ents != 32'd0)
        begin
            r.entries  = e.entries + p.ents;
            r.used_min = (p.used < e.used_min) ? p.used : e.used_min;
            r.used_max = (p.used > e.used_max) ? p.used : e.used_max;
            r.used_sum = e.used_sum + {32'd0, p.used};
            r.free_min = (p.spare < e.free_min) ? p.spare : e.free_min;
            r.free_max = (p.spare > e.free_max) ? p.spare : e.free_max;
            r.free_sum = e.free_sum + {32'd0, p.spare};
        end
        return r;
    endfunction

    // a new class starts its minimums from the page that opens it
    function automatic entry_t fresh_entry(page_t p);
        entry_t r;
        r            = '0;
        r.size_pages = p.pages;
        r.used_min   = p.used;
        r.free_min   = p.spare;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssc_ifs.sv */
// valid/ready channel interfaces for page requests and class results
// depends on nothing but the field widths of the block
`default_nettype none

interface ssc_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  read_index;
    logic [31:0] page_bytes;
    logic [31:0] overhead_bytes;
    logic [31:0] active_bytes;
    logic [31:0] active_entries;

    modport source (
        output valid, opcode, read_index, page_bytes, overhead_bytes,
               active_bytes, active_entries,
        input  ready
    );
    modport sink (
        input  valid, opcode, read_index, page_bytes, overhead_bytes,
               active_bytes, active_entries,
        output ready
    );
endinterface

interface ssc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  distinct_classes;
    logic [31:0] class_pages;
    logic [31:0] class_page_count;
    logic [31:0] class_entry_total;
    logic [31:0] class_min_used;
    logic [31:0] class_max_used;
    logic [63:0] class_sum_used;
    logic [31:0] class_min_free;
    logic [31:0] class_max_free;
    logic [63:0] class_sum_free;

    modport source (
        output valid, status, distinct_classes, class_pages, class_page_count,
               class_entry_total, class_min_used, class_max_used, class_sum_used,
               class_min_free, class_max_free, class_sum_free,
        input  ready
    );
    modport sink (
        input  valid, status, distinct_classes, class_pages, class_page_count,
               class_entry_total, class_min_used, class_max_used, class_sum_used,
               class_min_free, class_max_free, class_sum_free,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/ssc_cell.sv */
// one slot of the sorted class row: compares, updates, inserts or takes its left neighbor
// depends on ssc_pkg
`default_nettype none

module ssc_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ssc_pkg::cell_ctl_t   ctl,
    input  ssc_pkg::page_t       pg,
    input  ssc_pkg::cell_flags_t left_flags,
    input  ssc_pkg::entry_t      left_entry,
    output ssc_pkg::cell_flags_t flags,
    output ssc_pkg::entry_t      entry,
    output logic                 hit,
    output ssc_pkg::entry_t      result
);

    logic            valid_reg;
    logic            valid_next;
    ssc_pkg::entry_t entry_reg;
    ssc_pkg::entry_t entry_next;
    logic            ins;

    // compare against the broadcast page size
    always_comb
    begin
        flags.valid = valid_reg;
        flags.eq    = valid_reg && (entry_reg.size_pages == pg.pages);
        flags.gt    = valid_reg && (pg.pages < entry_reg.size_pages);
        flags.cand  = flags.gt || !valid_reg;
    end

    // first slot that is larger or empty takes the new class
    assign ins   = flags.cand && !left_flags.cand;
    assign entry = entry_reg;

    // update, insert or shift right
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        hit        = 1'b0;
        if (ctl.upd_en)
        begin
            if (flags.eq)
            begin
                entry_next = ssc_pkg::fold_page(entry_reg, pg);
                hit        = 1'b1;
            end
            else if (ctl.new_class)
            begin
                if (ins)
                begin
                    entry_next = ssc_pkg::fold_page(ssc_pkg::fresh_entry(pg), pg);
                    valid_next = 1'b1;
                    hit        = 1'b1;
                end
                else if (left_flags.gt)
                begin
                    entry_next = left_entry;
                    valid_next = 1'b1;
                end
            end
        end
        if (ctl.rd_sel && valid_reg)
        begin
            hit = 1'b1;
        end
    end

    assign result = hit ? entry_next : '0;

    // slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/sorted_size_class_stats_table.sv */
// Accepted words are registered in the input stage, result words in the output register.
// Throughput: one word per cycle while rsp does not stall; each word takes a single
// compare-and-shift step of the cell row, done before the next word reaches the row.
// Reset: all slots empty, class count zero, page size log2 = 12; no clearing pass.
// depends on ssc_pkg, ssc_ifs and ssc_cell
`default_nettype none

module sorted_size_class_stats_table #(
    parameter int TABLE_DEPTH = ssc_pkg::TABLE_DEPTH
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_wr_en,
    input  wire [ssc_pkg::CFG_W-1:0]    cfg_wr_data,
    ssc_req_if.sink                     req,
    ssc_rsp_if.source                   rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ssc_pkg::CFG_W-1:0] page_log2_reg;

    logic                      s1_valid_reg;
    ssc_pkg::opcode_t          s1_op_reg;
    logic [ssc_pkg::IDX_W-1:0] s1_idx_reg;
    ssc_pkg::page_t            s1_pg_reg;
    logic                      s1_under_reg;
    ssc_pkg::page_t            pg_in;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                 out_valid_reg;
    ssc_pkg::status_t     out_status_reg;
    logic [4:0]           out_classes_reg;
    ssc_pkg::entry_t      out_entry_reg;

    ssc_pkg::cell_flags_t flags_vec  [TABLE_DEPTH];
    ssc_pkg::entry_t      entry_vec  [TABLE_DEPTH];
    ssc_pkg::entry_t      result_vec [TABLE_DEPTH];
    ssc_pkg::cell_ctl_t   ctl_vec    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] valid_vec;

    logic             accept;
    logic             fire;
    logic             any_eq;
    logic             full;
    logic             is_rec;
    logic             drop;
    logic             upd_en;
    ssc_pkg::status_t status_next;
    ssc_pkg::entry_t  res_entry;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_log2_reg <= ssc_pkg::PAGE_LOG2_RESET;
        end
        else if (cfg_wr_en)
        begin
            page_log2_reg <= cfg_wr_data;
        end
    end

    // handshake
    assign fire      = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || fire;
    assign accept    = req.valid && req.ready;

    // page size in pages, used and free bytes
    always_comb
    begin
        pg_in.pages = req.page_bytes >> page_log2_reg;
        pg_in.used  = req.overhead_bytes + req.active_bytes;
        pg_in.spare = req.page_bytes - pg_in.used;
        pg_in.ents  = req.active_entries;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= ssc_pkg::opcode_t'(req.opcode);
            s1_idx_reg   <= req.read_index;
            s1_pg_reg    <= pg_in;
            s1_under_reg <= pg_in.pages < ssc_pkg::MIN_PAGES;
        end
    end

    // table-wide decisions
    assign any_eq = |eq_vec;
    assign full   = count_reg == CNT_W'(TABLE_DEPTH);
    assign is_rec = s1_op_reg == ssc_pkg::OP_RECORD;
    assign drop   = is_rec && !s1_under_reg && !any_eq && full;
    assign upd_en = fire && is_rec && !s1_under_reg && !drop;

    // cell row
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        ssc_pkg::cell_flags_t left_f;
        ssc_pkg::entry_t      left_e;

        if (k == 0)
        begin : g_first
            assign left_f = '0;
            assign left_e = '0;
        end
        else
        begin : g_rest
            assign left_f = flags_vec[k-1];
            assign left_e = entry_vec[k-1];
        end

        assign ctl_vec[k].upd_en    = upd_en;
        assign ctl_vec[k].new_class = !any_eq;
        assign ctl_vec[k].rd_sel    = (s1_op_reg == ssc_pkg::OP_READ)
                                      && (32'(s1_idx_reg) == 32'(k));
        assign eq_vec[k]            = flags_vec[k].eq;
        assign valid_vec[k]         = flags_vec[k].valid;

        ssc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl_vec[k]),
            .pg         (s1_pg_reg),
            .left_flags (left_f),
            .left_entry (left_e),
            .flags      (flags_vec[k]),
            .entry      (entry_vec[k]),
            .hit        (hit_vec[k]),
            .result     (result_vec[k])
        );
    end

    // gather the one selected class
    always_comb
    begin
        res_entry = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            res_entry = res_entry | result_vec[k];
        end
    end

    // class count
    assign count_next = count_reg + CNT_W'(upd_en && !any_eq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result status
    always_comb
    begin
        if (!is_rec)
        begin
            status_next = ssc_pkg::ST_OK;
        end
        else if (s1_under_reg)
        begin
            status_next = ssc_pkg::ST_IGNORED;
        end
        else if (drop)
        begin
            status_next = ssc_pkg::ST_DROPPED;
        end
        else
        begin
            status_next = ssc_pkg::ST_OK;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg  <= status_next;
            out_classes_reg <= 5'(count_next);
            out_entry_reg   <= res_entry;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.distinct_classes  = out_classes_reg;
    assign rsp.class_pages       = out_entry_reg.size_pages;
    assign rsp.class_page_count  = out_entry_reg.pages_seen;
    assign rsp.class_entry_total = out_entry_reg.entries;
    assign rsp.class_min_used    = out_entry_reg.used_min;
    assign rsp.class_max_used    = out_entry_reg.used_max;
    assign rsp.class_sum_used    = out_entry_reg.used_sum;
    assign rsp.class_min_free    = out_entry_reg.free_min;
    assign rsp.class_max_free    = out_entry_reg.free_max;
    assign rsp.class_sum_free    = out_entry_reg.free_sum;

`ifndef NO_ASSERTIONS
    // the number of occupied slots always equals the class count
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("class count differs from occupied slots");

    // never more classes than slots
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= TABLE_DEPTH)
        else $error("class count beyond table depth");

    // at most one slot supplies the result
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> $onehot0(hit_vec))
        else $error("more than one slot selected");

    // a dropped or ignored page or a read leaves the count alone
    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (drop || s1_under_reg || !is_rec)) |=> $stable(count_reg))
        else $error("class count moved on a page that changes nothing");

    // a recorded page is always reflected in exactly one slot
    a_record_hits: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en |-> $onehot(hit_vec))
        else $error("recorded page reached no slot");
`endif

endmodule

`default_nettype wire

/* dv/sorted_size_class_stats_table_tb.sv */
// testbench for the sorted size class stats table: directed and random page words,
// predicted class words checked field by field on the result channel
// depends on ssc_pkg, ssc_ifs and the sorted_size_class_stats_table rtl
`timescale 1ns / 1ps

module sorted_size_class_stats_table_tb;
    import ssc_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // one page word as offered on the request channel
    typedef struct packed {
        opcode_t     op;
        logic [3:0]  rd_idx;
        logic [31:0] bytes;
        logic [31:0] ovh;
        logic [31:0] act;
        logic [31:0] ents;
    } page_word_t;

    // one class word as returned on the result channel
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] classes;
        entry_t     cls;
    } class_word_t;

    // size class table shadow and the class words it still owes
    class class_stats_board;
        entry_t        slots[TABLE_DEPTH];
        int unsigned   held;
        logic [4:0]    log2_pages;
        class_word_t   owed_words[$];
        int unsigned   errors;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
                slots[i] = '0;
            held       = 0;
            log2_pages = PAGE_LOG2_RESET;
            errors     = 0;
        endfunction

        function void set_page_log2(logic [4:0] v);
            log2_pages = v;
        endfunction

        // fold an accepted page word into the shadow table and queue its class word
        function void note_word(page_word_t w);
            class_word_t exp;
            logic [31:0] pages;
            logic [31:0] used;
            logic [31:0] freeb;
            int unsigned pos;
            int unsigned k;
            bit          found;
            exp        = '0;
            exp.status = ST_OK;
            found      = 1'b0;
            if (w.op == OP_READ)
            begin
                if (w.rd_idx < held)
                    exp.cls = slots[w.rd_idx];
                exp.classes = 5'(held);
                owed_words.push_back(exp);
                return;
            end
            pages = w.bytes >> log2_pages;
            if (pages < MIN_PAGES)
            begin
                exp.status  = ST_IGNORED;
                exp.classes = 5'(held);
                owed_words.push_back(exp);
                return;
            end
            used  = w.ovh + w.act;
            freeb = w.bytes - used;
            // find the matching class or the sorted insertion point
            pos = held;
            for (k = 0; k < held; k++)
            begin
                if (slots[k].size_pages == pages)
                begin
                    pos   = k;
                    found = 1'b1;
                    break;
                end
                if (pages < slots[k].size_pages)
                begin
                    pos = k;
                    break;
                end
            end
            if (!found)
            begin
                if (held == TABLE_DEPTH)
                begin
                    exp.status  = ST_DROPPED;
                    exp.classes = 5'(held);
                    owed_words.push_back(exp);
                    return;
                end
                // shift larger classes down and open the new one
                for (k = held; k > pos; k--)
                    slots[k] = slots[k-1];
                slots[pos]            = '0;
                slots[pos].size_pages = pages;
                slots[pos].used_min   = used;
                slots[pos].free_min   = freeb;
                held++;
            end
            slots[pos].pages_seen = slots[pos].pages_seen + 32'd1;
            if (w.ents != 32'd0)
            begin
                slots[pos].entries  = slots[pos].entries + w.ents;
                if (used < slots[pos].used_min)
                    slots[pos].used_min = used;
                if (used > slots[pos].used_max)
                    slots[pos].used_max = used;
                slots[pos].used_sum = slots[pos].used_sum + {32'd0, used};
                if (freeb < slots[pos].free_min)
                    slots[pos].free_min = freeb;
                if (freeb > slots[pos].free_max)
                    slots[pos].free_max = freeb;
                slots[pos].free_sum = slots[pos].free_sum + {32'd0, freeb};
            end
            exp.classes = 5'(held);
            exp.cls     = slots[pos];
            owed_words.push_back(exp);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // compare a returned class word against the oldest owed one
        function void check_word(class_word_t got);
            class_word_t exp;
            if (owed_words.size() == 0)
            begin
                $error("class word with none owed: status %0h", got.status);
                errors++;
                return;
            end
            exp = owed_words.pop_front();
            check_field("status", exp.status, got.status);
            check_field("distinct_classes", exp.classes, got.classes);
            check_field("class_pages", exp.cls.size_pages, got.cls.size_pages);
            check_field("class_page_count", exp.cls.pages_seen, got.cls.pages_seen);
            check_field("class_entry_total", exp.cls.entries, got.cls.entries);
            check_field("class_min_used", exp.cls.used_min, got.cls.used_min);
            check_field("class_max_used", exp.cls.used_max, got.cls.used_max);
            check_field("class_sum_used", exp.cls.used_sum, got.cls.used_sum);
            check_field("class_min_free", exp.cls.free_min, got.cls.free_min);
            check_field("class_max_free", exp.cls.free_max, got.cls.free_max);
            check_field("class_sum_free", exp.cls.free_sum, got.cls.free_sum);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    bit                steady;
    int unsigned       idle_cycles;
    class_stats_board  board;

    ssc_req_if page_ch ();
    ssc_rsp_if class_ch ();

    sorted_size_class_stats_table i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (page_ch),
        .rsp         (class_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // stretches with no idling on either side
    always
    begin
        repeat ($urandom_range(40, 160)) @(posedge clk);
        steady <= ~steady;
    end

    // note accepted page words, check accepted class words
    always @(posedge clk)
    begin : word_monitor
        page_word_t  pw;
        class_word_t cw;
        if (rst_n)
        begin
            if (page_ch.valid && page_ch.ready)
            begin
                pw.op     = opcode_t'(page_ch.opcode);
                pw.rd_idx = page_ch.read_index;
                pw.bytes  = page_ch.page_bytes;
                pw.ovh    = page_ch.overhead_bytes;
                pw.act    = page_ch.active_bytes;
                pw.ents   = page_ch.active_entries;
                board.note_word(pw);
            end
            if (class_ch.valid && class_ch.ready)
            begin
                cw.status         = class_ch.status;
                cw.classes        = class_ch.distinct_classes;
                cw.cls.size_pages = class_ch.class_pages;
                cw.cls.pages_seen = class_ch.class_page_count;
                cw.cls.entries    = class_ch.class_entry_total;
                cw.cls.used_min   = class_ch.class_min_used;
                cw.cls.used_max   = class_ch.class_max_used;
                cw.cls.used_sum   = class_ch.class_sum_used;
                cw.cls.free_min   = class_ch.class_min_free;
                cw.cls.free_max   = class_ch.class_max_free;
                cw.cls.free_sum   = class_ch.class_sum_free;
                board.check_word(cw);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((page_ch.valid && page_ch.ready) || (class_ch.valid && class_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("sorted_size_class_stats_table verification failed");
                $finish;
            end
        end
    end

    // result side: random stall before each class word
    initial
    begin : class_sink
        int unsigned stall;
        class_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                class_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            class_ch.ready <= 1'b1;
            @(posedge clk);
            while (!class_ch.valid)
                @(posedge clk);
        end
    end

    function automatic page_word_t page_word(opcode_t op, logic [3:0] idx, logic [31:0] bytes,
                                             logic [31:0] ovh, logic [31:0] act,
                                             logic [31:0] ents);
        page_word_t w;
        w.op     = op;
        w.rd_idx = idx;
        w.bytes  = bytes;
        w.ovh    = ovh;
        w.act    = act;
        w.ents   = ents;
        return w;
    endfunction

    // random page word: held class sizes most often, some new, reads, small pages and noise
    function automatic page_word_t draw_page_word();
        page_word_t  w;
        int unsigned pick;
        logic [63:0] span;
        logic [63:0] base;
        logic [31:0] pages;
        w.op     = OP_RECORD;
        w.rd_idx = 4'($urandom);
        w.bytes  = $urandom;
        w.ovh    = $urandom;
        w.act    = $urandom;
        w.ents   = ($urandom_range(0, 9) < 3) ? 32'd0 : 32'($urandom);
        span     = 64'd1 << board.log2_pages;
        pick     = $urandom_range(0, 99);
        if (pick < 12)
            w.op = OP_READ;
        else if (pick < 20)
        begin
            // noise: all fields as drawn
        end
        else if (pick < 28)
            w.bytes = 32'($urandom) & 32'(2 * span - 64'd1);
        else
        begin
            if (pick < 70 && board.held > 0)
                pages = board.slots[$urandom_range(0, board.held - 1)].size_pages;
            else
                pages = $urandom_range(2, 60);
            base = {32'd0, pages} << board.log2_pages;
            if (base[63:32] == 32'd0)
                w.bytes = base[31:0] | (32'($urandom) & 32'(span - 64'd1));
            if ($urandom_range(0, 1) == 0)
            begin
                w.ovh = $urandom_range(0, w.bytes / 4);
                w.act = $urandom_range(0, w.bytes / 2);
            end
        end
        return w;
    endfunction

    // offer one page word after a random gap and hold it until taken
    task automatic send_word(page_word_t w);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            page_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        page_ch.valid          <= 1'b1;
        page_ch.opcode         <= w.op;
        page_ch.read_index     <= w.rd_idx;
        page_ch.page_bytes     <= w.bytes;
        page_ch.overhead_bytes <= w.ovh;
        page_ch.active_bytes   <= w.act;
        page_ch.active_entries <= w.ents;
        @(posedge clk);
        while (!page_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_words();
        page_ch.valid <= 1'b0;
        while (board.owed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the page size register once the block is idle
    task automatic write_page_log2(logic [4:0] v);
        drain_words();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_page_log2(v);
    endtask

    task automatic send_random(int unsigned n);
        repeat (n) send_word(draw_page_word());
    endtask

    initial
    begin
        board                  = new();
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        page_ch.valid          = 1'b0;
        page_ch.opcode         = OP_RECORD;
        page_ch.read_index     = '0;
        page_ch.page_bytes     = '0;
        page_ch.overhead_bytes = '0;
        page_ch.active_bytes   = '0;
        page_ch.active_entries = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset page size of 4 KiB
        send_word(page_word(OP_READ,   4'd0,  32'd0, 32'd0, 32'd0, 32'd0));
        send_word(page_word(OP_RECORD, 4'd0,  32'd0, 32'd0, 32'd0, 32'd5));
        send_word(page_word(OP_RECORD, 4'd0,  32'd8191, 32'd10, 32'd20, 32'd1));
        // new class with no entries: minimums still come from this page
        send_word(page_word(OP_RECORD, 4'd0,  32'd20480, 32'd100, 32'd200, 32'd0));
        send_word(page_word(OP_RECORD, 4'd0,  32'd12305, 32'd64, 32'd900, 32'd1));
        send_word(page_word(OP_RECORD, 4'd0,  32'd36864, 32'd48, 32'd4000, 32'd3));
        send_word(page_word(OP_RECORD, 4'd0,  32'd28672, 32'd32, 32'd1000, 32'd2));
        // used and entry totals wrap
        send_word(page_word(OP_RECORD, 4'd0,  32'd20480, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_word(page_word(OP_RECORD, 4'd0,  32'd20480, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_word(page_word(OP_RECORD, 4'd0,  32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1));
        // free wraps when used exceeds the page
        send_word(page_word(OP_RECORD, 4'd0,  32'd8192, 32'h0001_0000, 32'd0, 32'd2));
        send_word(page_word(OP_RECORD, 4'd0,  32'd36864, 32'd8, 32'd16, 32'd7));
        // reads inside and beyond the held classes
        send_word(page_word(OP_READ,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_word(page_word(OP_READ,   4'd0,  32'd0, 32'd0, 32'd0, 32'd0));
        send_word(page_word(OP_READ,   4'd2,  32'd0, 32'd0, 32'd0, 32'd0));
        send_word(page_word(OP_READ,   4'd5,  32'd0, 32'd0, 32'd0, 32'd0));
        send_word(page_word(OP_READ,   4'd6,  32'd0, 32'd0, 32'd0, 32'd0));

        // random phases across page sizes, out-of-range shifts among them
        send_random(300);
        write_page_log2(5'd7);
        send_random(200);
        write_page_log2(5'd16);
        send_random(200);
        write_page_log2(5'd0);
        send_random(200);
        write_page_log2(5'd31);
        send_random(100);
        write_page_log2(5'($urandom_range(0, 31)));
        send_random(150);
        write_page_log2(5'd12);
        send_random(200);

        drain_words();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.owed_words.size() == 0)
            $display("sorted_size_class_stats_table verification clean");
        else
            $display("sorted_size_class_stats_table verification failed");
        $finish;
    end

endmodule
